>>> rtl/core/vlpd_pkg.sv
// Shared types and codes for the varint length-prefix deframer.
package vlpd_pkg;

    // Field widths fixed by the stream format
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 17;

    // Reset value of the maximum frame length register
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(16 * 1024);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [1:0]        t_status;
    typedef logic [1:0]        t_phase;
    typedef logic [1:0]        t_group;

    // Result status codes
    localparam t_status ST_PAYLOAD   = 2'd0;
    localparam t_status ST_TOO_LARGE = 2'd1;
    localparam t_status ST_MALFORMED = 2'd2;

    // Deframer phases
    localparam t_phase PH_HEADER  = 2'd0;
    localparam t_phase PH_PAYLOAD = 2'd1;
    localparam t_phase PH_HALT    = 2'd2;

    // Position of a header byte's seven value bits in the length
    localparam t_group GRP_LOW    = 2'd0;
    localparam t_group GRP_MID    = 2'd1;
    localparam t_group GRP_HIGH   = 2'd2;
    localparam t_group GRP_BEYOND = 2'd3;

    // Header decode result handed back to the control logic
    typedef struct packed {
        t_len accum;
        logic over;
        logic zero;
        logic too_large;
    } t_hdr_dec;

endpackage

>>> rtl/core/vlpd_stream_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface vlpd_in_if;
    import vlpd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface vlpd_out_if;
    import vlpd_pkg::*;

    logic    valid;
    logic    ready;
    t_byte   payload_byte;
    logic    last_in_frame;
    t_status status;

    modport source (output valid, output payload_byte, output last_in_frame,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input last_in_frame,
                    input status, output ready);
endinterface

>>> rtl/core/vlpd_hdr_decode.sv
// Header byte decoder: merges seven value bits into the saturating length.
module vlpd_hdr_decode (
    input  vlpd_pkg::t_byte    i_byte,
    input  vlpd_pkg::t_group   i_group,
    input  vlpd_pkg::t_len     i_accum,
    input  logic               i_over,
    input  vlpd_pkg::t_len     i_max_len,
    output vlpd_pkg::t_hdr_dec o_dec
);
    import vlpd_pkg::*;

    logic [6:0]       bits;
    logic [LEN_W+3:0] shifted;
    logic [LEN_W+3:0] merged;
    logic             spill;
    logic             fits;

    assign bits = i_byte[6:0];

    // Place the value bits by header byte position
    always_comb begin
        case (i_group)
            GRP_LOW:  shifted = {14'd0, bits};
            GRP_MID:  shifted = {7'd0, bits, 7'd0};
            GRP_HIGH: shifted = {bits, 14'd0};
            default:  shifted = '0;
        endcase
    end

    assign merged = {4'd0, i_accum} | shifted;
    assign spill  = (bits != 7'd0) &&
                    ((i_group == GRP_BEYOND) || (merged[LEN_W+3:LEN_W] != 4'd0));
    assign fits   = (bits != 7'd0) && !spill;

    // Saturate: once the length leaves 17 bits only the flag matters
    always_comb begin
        o_dec.over      = i_over | spill;
        o_dec.accum     = fits ? merged[LEN_W-1:0] : i_accum;
        o_dec.zero      = !o_dec.over && (o_dec.accum == '0);
        o_dec.too_large = o_dec.over || (o_dec.accum > i_max_len);
    end

endmodule

>>> rtl/core/varint_length_prefix_deframer.sv
// Top level of the varint length-prefix deframer.
//
//  channel   dir  payload                                   accepted when
//  i_in      in   data_byte[7:0]                            valid && ready
//  o_out     out  payload_byte[7:0], last_in_frame, status  valid && ready
//  i_cfg     in   i_cfg_wr_data[16:0] (max_frame_len)       i_cfg_wr_en
//
//  One byte per cycle sustained while results are not stalled; a result
//  appears when its byte moves from the input register to the result
//  register. The header/payload state advances once per byte, which sets that rate.
//  Reset is synchronous: phase, header count, length and valids clear, and
//  max_frame_len returns to 16384. A stalled result holds the result
//  register; the input register still takes one byte behind it if it is empty.
module varint_length_prefix_deframer #(
    parameter int HEADER_BYTES_MAX = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vlpd_in_if.sink               i_in,
    vlpd_out_if.source            o_out,
    input  logic                  i_cfg_wr_en,
    input  vlpd_pkg::t_len        i_cfg_wr_data
);
    import vlpd_pkg::*;

    localparam int CNT_W = $clog2(HEADER_BYTES_MAX + 1);

    logic             r_in_valid;
    t_byte            r_in_byte;
    logic             r_out_valid;
    t_byte            r_out_byte;
    logic             r_out_last;
    t_status          r_out_status;
    t_phase           r_phase,   n_phase;
    logic [CNT_W-1:0] r_hdr_cnt, n_hdr_cnt;
    t_len             r_accum,   n_accum;
    logic             r_over,    n_over;
    t_len             r_remain,  n_remain;
    t_len             r_max_len;

    logic     out_free;
    logic     adv;
    logic     n_emit;
    t_byte    n_byte;
    logic     n_last;
    t_status  n_status;
    t_group   group;
    t_hdr_dec dec;

    // Handshake: the result slot frees the input register
    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign o_out.valid         = r_out_valid;
    assign o_out.payload_byte  = r_out_byte;
    assign o_out.last_in_frame = r_out_last;
    assign o_out.status        = r_out_status;

    // Map header byte count to its value-bit group
    always_comb begin
        if (r_hdr_cnt > CNT_W'(2)) begin
            group = GRP_BEYOND;
        end else begin
            group = t_group'(r_hdr_cnt);
        end
    end

    vlpd_hdr_decode u_hdr_decode (
        .i_byte    (r_in_byte),
        .i_group   (group),
        .i_accum   (r_accum),
        .i_over    (r_over),
        .i_max_len (r_max_len),
        .o_dec     (dec)
    );

    // Advance the deframer state by one byte
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_accum   = r_accum;
        n_over    = r_over;
        n_remain  = r_remain;
        n_emit    = 1'b0;
        n_byte    = '0;
        n_last    = 1'b0;
        n_status  = ST_PAYLOAD;
        if (adv) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + CNT_W'(1);
                    n_accum   = dec.accum;
                    n_over    = dec.over;
                    if (r_in_byte[7]) begin
                        if (r_hdr_cnt == CNT_W'(HEADER_BYTES_MAX - 1)) begin
                            n_phase  = PH_HALT;
                            n_emit   = 1'b1;
                            n_status = ST_MALFORMED;
                        end
                    end else if (dec.zero) begin
                        // drop an empty frame and hunt for the next header
                        n_hdr_cnt = '0;
                        n_accum   = '0;
                        n_over    = 1'b0;
                    end else if (dec.too_large) begin
                        n_phase  = PH_HALT;
                        n_emit   = 1'b1;
                        n_status = ST_TOO_LARGE;
                    end else begin
                        n_remain = dec.accum;
                        n_phase  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_remain = r_remain - LEN_W'(1);
                    n_emit   = 1'b1;
                    n_byte   = r_in_byte;
                    n_last   = (r_remain == LEN_W'(1));
                    if (n_last) begin
                        n_phase = PH_HALT;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_accum     <= '0;
            r_over      <= 1'b0;
            r_remain    <= '0;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= n_emit;
            end
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_accum   <= n_accum;
            r_over    <= n_over;
            r_remain  <= n_remain;
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (n_emit) begin
            r_out_byte   <= n_byte;
            r_out_last   <= n_last;
            r_out_status <= n_status;
        end
    end

endmodule

>>> rtl/core/vlpd_checker.sv
// Port-level checker for the deframer, bound to the top level.
module vlpd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input vlpd_pkg::t_byte   i_payload_byte,
    input logic             i_last_in_frame,
    input vlpd_pkg::t_status i_status
);
    import vlpd_pkg::*;

    // A stalled result holds its request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_payload_byte)
            && $stable(i_last_in_frame) && $stable(i_status)))
        else $error("result changed while stalled");

    // Error results carry a zero byte and no last mark
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_PAYLOAD) |-> (i_payload_byte == '0 && !i_last_in_frame))
        else $error("error result with payload data");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_PAYLOAD || i_status == ST_TOO_LARGE
            || i_status == ST_MALFORMED))
        else $error("undefined status code");

    // Nothing follows a final byte or an error
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && (i_last_in_frame || i_status != ST_PAYLOAD))
            |=> !i_out_valid)
        else $error("result after frame end or error");

endmodule

bind varint_length_prefix_deframer vlpd_checker u_vlpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_payload_byte  (o_out.payload_byte),
    .i_last_in_frame (o_out.last_in_frame),
    .i_status        (o_out.status)
);

>>> verif/vlpd_checker.sv
// Watches the deframer channels, predicts each result and compares it with the DUT output.
module vlpd_tb_checker #(
    parameter int HEADER_BYTES_MAX = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    vlpd_in_if             i_in,
    vlpd_out_if            i_out,
    input  logic           i_cfg_wr_en,
    input  vlpd_pkg::t_len i_cfg_wr_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vlpd_pkg::*;

    typedef struct packed {
        t_byte   payload_byte;
        logic    last_in_frame;
        t_status status;
    } t_frame_result;

    // Shadow copy of the deframer state and its length limit
    t_phase        dec_phase;
    logic [3:0]    hdr_count;
    t_len          len_accum;
    logic          len_over;
    t_len          bytes_left;
    t_len          max_len;

    t_frame_result expected_results[$];
    t_frame_result want;
    t_frame_result got;
    int            fails = 0;
    int            results_seen = 0;
    int            waiting = 0;

    assign o_fail_count   = fails;
    assign o_pending      = waiting;
    assign o_result_count = results_seen;

    function automatic void clear_header();
        hdr_count = '0;
        len_accum = '0;
        len_over  = 1'b0;
    endfunction

    // Advance the shadow state by one stream byte; return 1 when it yields a result
    function automatic bit deframe_byte(input t_byte b, output t_frame_result res);
        logic [6:0]  bits;
        logic [3:0]  idx;
        logic [23:0] merged;
        bits = b[6:0];
        idx  = hdr_count;
        res  = '0;
        case (dec_phase)
            PH_HEADER: begin
                // Merge the seven value bits; anything past 17 bits marks overflow
                if (bits != 7'd0) begin
                    if (idx <= 4'(GRP_HIGH)) begin
                        merged = 24'(len_accum) | (24'(bits) << (7 * idx));
                        if (merged > 24'(17'h1FFFF)) begin
                            len_over = 1'b1;
                        end else begin
                            len_accum = merged[LEN_W-1:0];
                        end
                    end else begin
                        len_over = 1'b1;
                    end
                end
                hdr_count = idx + 4'd1;
                if (b[7]) begin
                    if (int'(idx) + 1 >= HEADER_BYTES_MAX) begin
                        dec_phase  = PH_HALT;
                        res.status = ST_MALFORMED;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                // Skip a zero-length header and start over
                if (!len_over && len_accum == '0) begin
                    clear_header();
                    return 1'b0;
                end
                if (len_over || len_accum > max_len) begin
                    dec_phase  = PH_HALT;
                    res.status = ST_TOO_LARGE;
                    return 1'b1;
                end
                bytes_left = len_accum;
                dec_phase  = PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                bytes_left        = bytes_left - 1'b1;
                res.payload_byte  = b;
                res.last_in_frame = (bytes_left == '0);
                res.status        = ST_PAYLOAD;
                if (res.last_in_frame) begin
                    dec_phase = PH_HALT;
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_phase  = PH_HEADER;
            clear_header();
            bytes_left = '0;
            max_len    = MAX_LEN_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                max_len = i_cfg_wr_data;
            end
            // Compare an accepted result with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                results_seen++;
                got.payload_byte  = i_out.payload_byte;
                got.last_in_frame = i_out.last_in_frame;
                got.status        = i_out.status;
                if (expected_results.size() == 0) begin
                    $error({"result with nothing expected: ",
                            "payload_byte %0h last_in_frame %0d status %0d"},
                           got.payload_byte, got.last_in_frame, got.status);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.payload_byte !== want.payload_byte) begin
                        $error("payload_byte mismatch: expected %0h, actual %0h",
                               want.payload_byte, got.payload_byte);
                        fails++;
                    end
                    if (got.last_in_frame !== want.last_in_frame) begin
                        $error("last_in_frame mismatch: expected %0d, actual %0d",
                               want.last_in_frame, got.last_in_frame);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                end
            end
            // Predict from each accepted stream byte
            if (i_in.valid && i_in.ready) begin
                if (deframe_byte(i_in.data_byte, want)) begin
                    expected_results.push_back(want);
                end
            end
        end
        waiting = expected_results.size();
    end

endmodule

>>> verif/varint_length_prefix_deframer_test.sv
// Stimulus and verdict for the varint length-prefix deframer, checked by vlpd_tb_checker.
module varint_length_prefix_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import vlpd_pkg::*;

    localparam int HDR_MAX       = 10;
    localparam int STREAM_BYTES  = 1950;
    localparam int NOISE_BYTES   = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef enum int {END_FRAME, END_TOO_LARGE, END_MALFORMED} t_ending;

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_wr_en;
    t_len  cfg_wr_data;
    int    fail_count;
    int    pending;
    int    result_count;
    int    bytes_sent = 0;
    int    zero_headers = 0;
    int    cfg_writes = 0;
    int    cycle_count = 0;
    int    send_burst = 0;
    int    recv_burst = 0;

    vlpd_in_if  in_ch ();
    vlpd_out_if out_ch ();

    varint_length_prefix_deframer #(
        .HEADER_BYTES_MAX (HDR_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    vlpd_tb_checker #(
        .HEADER_BYTES_MAX (HDR_MAX)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle length: mostly none, some short, a few long, and now and then a burst with none
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r < 2) begin
            burst = $urandom_range(50, 200);
            return 0;
        end
        if (r < 120) return 0;
        if (r < 180) return $urandom_range(1, 3);
        if (r < 196) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_len pick_limit();
        case ($urandom_range(0, 3))
            0: return t_len'(1);
            1: return t_len'(65536);
            default: return t_len'($urandom_range(1, 65536));
        endcase
    endfunction

    // Offer one byte, hold it until taken, then idle at random
    task automatic push_byte(input t_byte b);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write the length limit once the block has drained
    task automatic set_max_len(input t_len value);
        in_ch.valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    task automatic send_zero_header(input int n);
        for (int i = 0; i < n; i++) begin
            push_byte({(i < n - 1), 7'd0});
        end
        zero_headers++;
    endtask

    // Encode a length LSB group first, padded with empty groups to pad_to bytes
    task automatic send_varint(input longint unsigned value, input int pad_to);
        int              groups;
        longint unsigned rest;
        groups = 1;
        rest   = value >> 7;
        while (rest != 0) begin
            groups++;
            rest = rest >> 7;
        end
        if (pad_to > groups) groups = pad_to;
        for (int i = 0; i < groups; i++) begin
            push_byte({(i < groups - 1), 7'(value >> (7 * i))});
        end
    endtask

    // Result side: one long hold-off on the first result, random stalls otherwise
    initial begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && out_ch.valid === 1'b1) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                stall = pick_gap(recv_burst);
                out_ch.ready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    // Bound the run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("varint_length_prefix_deframer_test: FAIL");
        $finish;
    end

    initial begin
        t_ending ending;
        string   ending_name;
        int      frame_len;
        int      n;
        int      limit;
        int      pad;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        i_rst_n         <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: limit extremes, minimal and padded zero-length headers
        set_max_len(t_len'(1));
        send_zero_header(1);
        set_max_len(t_len'(65536));
        send_zero_header(2);
        send_zero_header(3);
        send_zero_header(HDR_MAX);
        set_max_len(MAX_LEN_RESET);

        // Pick how this run's single frame ends; the block halts after it
        n = $urandom_range(0, 9);
        ending = (n < 7) ? END_FRAME : (n < 9) ? END_TOO_LARGE : END_MALFORMED;
        frame_len = 0;
        if (ending == END_FRAME) begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8)
                                                    : $urandom_range(300, 1200);
        end

        // Random zero-length headers with limit changes between them
        while (bytes_sent < STREAM_BYTES - NOISE_BYTES - frame_len - HDR_MAX) begin
            if ($urandom_range(0, 39) == 0) set_max_len(pick_limit());
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, HDR_MAX);
            send_zero_header(n);
        end

        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(2, HDR_MAX) : 0;
        case (ending)
            END_FRAME: begin
                ending_name = $sformatf("frame of %0d bytes", frame_len);
                case ($urandom_range(0, 2))
                    0: limit = frame_len;
                    1: limit = 65536;
                    default: limit = $urandom_range(frame_len, 65536);
                endcase
                set_max_len(t_len'(limit));
                send_varint(frame_len, pad);
                for (int i = 0; i < frame_len; i++) begin
                    case (i)
                        0: push_byte(8'h00);
                        1: push_byte(8'hFF);
                        2: push_byte(8'h80);
                        3: push_byte(8'h7F);
                        default: push_byte(t_byte'($urandom));
                    endcase
                end
            end
            END_TOO_LARGE: begin
                ending_name = "too-large header";
                case ($urandom_range(0, 2))
                    0: begin
                        limit = $urandom_range(1, 65535);
                        set_max_len(t_len'(limit));
                        send_varint(limit + 1, pad);
                    end
                    1: begin
                        set_max_len(t_len'(65536));
                        send_varint($urandom_range(65537, (1 << 21) - 1), pad);
                    end
                    default: begin
                        // Value bits past the third group overflow the length
                        set_max_len(pick_limit());
                        n = $urandom_range(4, HDR_MAX);
                        for (int i = 0; i < n - 1; i++) push_byte({1'b1, 7'($urandom)});
                        push_byte({1'b0, 7'($urandom_range(1, 127))});
                    end
                endcase
            end
            default: begin
                ending_name = "malformed header";
                for (int i = 0; i < HDR_MAX; i++) push_byte({1'b1, 7'($urandom)});
            end
        endcase

        // The halted block must ignore whatever follows
        repeat (NOISE_BYTES) push_byte(t_byte'($urandom));

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d stream bytes, %0d zero-length headers, %0d limit writes",
                 bytes_sent, zero_headers, cfg_writes);
        $display("run ended with %s; %0d results checked", ending_name, result_count);
        if (fail_count == 0) begin
            $display("varint_length_prefix_deframer_test: PASS");
        end else begin
            $display("varint_length_prefix_deframer_test: FAIL");
        end
        $finish;
    end

endmodule
